@@ src/bcrh_pkg.sv @@
// ----------------------------------------------------------------------------
// bcrh_pkg: shared types and constants for the climb reach heap block
// Request payloads, configuration port widths and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bcrh_pkg;

  // Fixed field widths
  localparam int HEIGHT_W   = 20;
  localparam int INDEX_W    = 16;
  localparam int BRICK_W    = 30;
  localparam int LADDER_W   = 11;
  localparam int BAL_W      = 32;
  localparam int LADDERS_W  = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  // Parameter defaults
  localparam int HEAP_DEPTH_DEF  = 1024;
  localparam int HEIGHT_BITS_DEF = 20;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                first;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] reached_index;
    logic               stopped;
    logic               heap_overflow;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;          // capture input request
    logic reload;        // open a new sequence
    logic charge;        // charge climb to bricks, note full store
    logic spend;         // spend one ladder
    logic push_open;     // start insert at the tail
    logic rd_parent;
    logic rd_top;
    logic rd_left;
    logic rd_right;
    logic wr_val;        // write pending climb at cursor
    logic wr_rd;         // move parent down, cursor to parent
    logic keep_left;     // hold left child
    logic move_best;     // move larger child up, cursor to it
    logic move_child;    // move held left child up, cursor to it
    logic refund_climb;
    logic refund_top;
    logic idx_zero;
    logic finish;        // advance position or stop
    logic post;          // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic first;
    logic halted;
    logic climb;
    logic neg;
    logic full;
    logic empty;
    logic at_root;
    logic has_child;
    logic has_right;
    logic parent_ge;
    logic climb_ge_rd;
    logic best_le_v;
    logic child_le_v;
  } status_t;

endpackage

`default_nettype wire

@@ src/bcrh_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcrh_ctrl: sequencer for the climb reach heap
// Walks one request through evaluation, heap insert or top replacement, and
// result posting. Owns the handshake state of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module bcrh_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire bcrh_pkg::status_t status,
  output bcrh_pkg::cmd_t        cmd
);
  import bcrh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_REF_CLIMB,
    S_TOP_CMP,
    S_PUSH_CHK,
    S_PUSH_CMP,
    S_SD_CHK,
    S_SD_L,
    S_SD_R,
    S_SD_MOVE,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.first) begin
          cmd.reload = 1'b1;
          state_nxt  = S_OUT;
        end else if (status.halted) begin
          state_nxt = S_OUT;
        end else if (!status.climb) begin
          state_nxt = S_FIN;
        end else if (!status.neg) begin
          cmd.charge = 1'b1;
          if (status.full) begin
            state_nxt = S_FIN;
          end else begin
            cmd.push_open = 1'b1;
            state_nxt     = S_PUSH_CHK;
          end
        end else begin
          cmd.charge = 1'b1;
          cmd.spend  = 1'b1;
          if (status.empty) begin
            state_nxt = S_REF_CLIMB;
          end else begin
            cmd.rd_top = 1'b1;
            state_nxt  = S_TOP_CMP;
          end
        end
      end
      S_REF_CLIMB: begin
        cmd.refund_climb = 1'b1;
        state_nxt        = S_FIN;
      end
      // Replace the top only when it beats the new climb
      S_TOP_CMP: begin
        if (status.climb_ge_rd) begin
          cmd.refund_climb = 1'b1;
          state_nxt        = S_FIN;
        end else begin
          cmd.refund_top = 1'b1;
          cmd.idx_zero   = 1'b1;
          state_nxt      = S_SD_CHK;
        end
      end
      S_PUSH_CHK: begin
        if (status.at_root) begin
          cmd.wr_val = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        if (status.parent_ge) begin
          cmd.wr_val = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.wr_rd = 1'b1;
          state_nxt = S_PUSH_CHK;
        end
      end
      S_SD_CHK: begin
        if (!status.has_child) begin
          cmd.wr_val = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_left = 1'b1;
          state_nxt   = S_SD_L;
        end
      end
      S_SD_L: begin
        cmd.keep_left = 1'b1;
        if (status.has_right) begin
          cmd.rd_right = 1'b1;
          state_nxt    = S_SD_R;
        end else begin
          state_nxt = S_SD_MOVE;
        end
      end
      S_SD_R: begin
        if (status.best_le_v) begin
          cmd.wr_val = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.move_best = 1'b1;
          state_nxt     = S_SD_CHK;
        end
      end
      S_SD_MOVE: begin
        if (status.child_le_v) begin
          cmd.wr_val = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.move_child = 1'b1;
          state_nxt      = S_SD_CHK;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      // Hold until the result register is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/bcrh_dp.sv @@
// ----------------------------------------------------------------------------
// bcrh_dp: datapath for the climb reach heap
// Budget registers, brick balance, ladder count, position tracking and the
// climb store kept as a binary max-heap in a single-port-read memory.
// ----------------------------------------------------------------------------
`default_nettype none

module bcrh_dp #(
  parameter int HEAP_DEPTH  = bcrh_pkg::HEAP_DEPTH_DEF,
  parameter int HEIGHT_BITS = bcrh_pkg::HEIGHT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bcrh_pkg::in_t                     in_data,
  input  wire logic                              cfg_valid,
  input  wire logic [bcrh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bcrh_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire bcrh_pkg::cmd_t                    cmd,
  output bcrh_pkg::status_t                      status,
  output bcrh_pkg::out_t                         out_data
);
  import bcrh_pkg::*;

  localparam int HW = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int XW = AW + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BRICK_BUDGET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LADDER_COUNT = CFG_IDX_W'(1);

  logic [BRICK_W-1:0]         budget_r;
  logic [LADDER_W-1:0]        ladder_cnt_r;
  logic [HW-1:0]              h_r;
  logic                       first_r;
  logic [HW-1:0]              prev_r;
  logic signed [BAL_W-1:0]    bal_r;
  logic signed [LADDERS_W-1:0] ladders_r;
  logic [CW-1:0]              count_r;
  logic [INDEX_W-1:0]         pos_r;
  logic                       halted_r;
  logic                       ovf_r;
  logic [HW-1:0]              v_r;
  logic [AW-1:0]              idx_r;
  logic [HW-1:0]              child_r;
  logic [AW-1:0]              child_idx_r;
  logic [HW-1:0]              rd_r;
  out_t                       out_r;

  logic [HW-1:0] mem [HEAP_DEPTH];

  logic [HW-1:0]           climb_w;
  logic signed [BAL_W-1:0] bal_sub;
  logic [AW-1:0]           parent_w;
  logic [XW-1:0]           c_w;
  logic [XW-1:0]           c1_w;
  logic                    right_big;
  logic [HW-1:0]           best_val;
  logic [AW-1:0]           best_idx;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [HW-1:0]           wr_data;

  // Climb cost and heap index arithmetic
  assign climb_w   = h_r - prev_r;
  assign bal_sub   = bal_r - $signed(BAL_W'(climb_w));
  assign parent_w  = (idx_r - AW'(1)) >> 1;
  assign c_w       = XW'({idx_r, 1'b1});
  assign c1_w      = c_w + XW'(1);
  assign right_big = rd_r > child_r;
  assign best_val  = right_big ? rd_r : child_r;
  assign best_idx  = right_big ? c1_w[AW-1:0] : child_idx_r;

  always_comb begin
    status             = '0;
    status.first       = first_r;
    status.halted      = halted_r;
    status.climb       = h_r > prev_r;
    status.neg         = bal_sub[BAL_W-1];
    status.full        = (count_r == CW'(HEAP_DEPTH));
    status.empty       = (count_r == '0);
    status.at_root     = (idx_r == '0);
    status.has_child   = c_w < XW'(count_r);
    status.has_right   = c1_w < XW'(count_r);
    status.parent_ge   = rd_r >= v_r;
    status.climb_ge_rd = v_r >= rd_r;
    status.best_le_v   = best_val <= v_r;
    status.child_le_v  = child_r <= v_r;
  end

  // Memory port selection
  always_comb begin
    rd_en   = cmd.rd_parent | cmd.rd_top | cmd.rd_left | cmd.rd_right;
    rd_addr = '0;
    if (cmd.rd_parent) begin
      rd_addr = parent_w;
    end else if (cmd.rd_left) begin
      rd_addr = c_w[AW-1:0];
    end else if (cmd.rd_right) begin
      rd_addr = c1_w[AW-1:0];
    end
    wr_en   = cmd.wr_val | cmd.wr_rd | cmd.move_best | cmd.move_child;
    wr_data = v_r;
    if (cmd.wr_rd) begin
      wr_data = rd_r;
    end else if (cmd.move_best) begin
      wr_data = best_val;
    end else if (cmd.move_child) begin
      wr_data = child_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Payload-only registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h_r     <= in_data.height[HW-1:0];
      first_r <= in_data.first;
    end
    if (cmd.charge) begin
      v_r <= climb_w;
    end
    if (cmd.keep_left) begin
      child_r     <= rd_r;
      child_idx_r <= c_w[AW-1:0];
    end
    if (cmd.push_open) begin
      idx_r <= count_r[AW-1:0];
    end else if (cmd.idx_zero) begin
      idx_r <= '0;
    end else if (cmd.wr_rd) begin
      idx_r <= parent_w;
    end else if (cmd.move_best) begin
      idx_r <= best_idx;
    end else if (cmd.move_child) begin
      idx_r <= child_idx_r;
    end
    if (cmd.post) begin
      out_r.reached_index <= pos_r;
      out_r.stopped       <= halted_r;
      out_r.heap_overflow <= ovf_r;
    end
  end

  // Sequence state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r     <= '0;
      ladder_cnt_r <= '0;
      prev_r       <= '0;
      bal_r        <= '0;
      ladders_r    <= '0;
      count_r      <= '0;
      pos_r        <= '0;
      halted_r     <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BRICK_BUDGET: budget_r     <= cfg_data[BRICK_W-1:0];
          CFG_LADDER_COUNT: ladder_cnt_r <= cfg_data[LADDER_W-1:0];
          default: ;
        endcase
      end
      if (cmd.reload) begin
        bal_r     <= $signed(BAL_W'(budget_r));
        ladders_r <= $signed(LADDERS_W'(ladder_cnt_r));
        count_r   <= '0;
        pos_r     <= '0;
        halted_r  <= 1'b0;
        ovf_r     <= 1'b0;
        prev_r    <= h_r;
      end
      if (cmd.charge) begin
        bal_r <= bal_sub;
        if (count_r == CW'(HEAP_DEPTH)) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.refund_climb) begin
        bal_r <= bal_r + $signed(BAL_W'(v_r));
      end
      if (cmd.refund_top) begin
        bal_r <= bal_r + $signed(BAL_W'(rd_r));
      end
      if (cmd.spend) begin
        ladders_r <= ladders_r - LADDERS_W'(1);
      end
      if (cmd.push_open) begin
        count_r <= count_r + CW'(1);
      end
      // Stop on exhausted ladders, else step forward
      if (cmd.finish) begin
        if (ladders_r[LADDERS_W-1]) begin
          halted_r <= 1'b1;
        end else begin
          prev_r <= h_r;
          if (pos_r != '1) begin
            pos_r <= pos_r + INDEX_W'(1);
          end
        end
      end
    end
  end

  assign out_data = out_r;

  // Store never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HEAP_DEPTH))
    else $error("climb store count beyond depth");

  // Stopped sequences always have a negative ladder count
  a_halt_ladders: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> ladders_r[LADDERS_W-1])
    else $error("stopped without exhausted ladders");

  // Heap writes stay inside the filled region
  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (XW'(idx_r) < XW'(count_r)))
    else $error("heap write outside filled region");

  // Balance is settled non-negative by the time a result is posted
  a_bal_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> !bal_r[BAL_W-1])
    else $error("brick balance negative at result");

endmodule

`default_nettype wire

@@ src/budgeted_climb_reach_heap.sv @@
// ----------------------------------------------------------------------------
// budgeted_climb_reach_heap: furthest building reachable with bricks/ladders
//
// Input channel (in_valid/in_ready/in_data) takes one building height per
// request; first = 1 opens a new sequence and reloads the brick and ladder
// budgets. Each request yields one result on out_valid/out_ready/out_data:
// furthest index reached, stopped flag and climb store overflow flag.
// Budgets are written on cfg_valid/cfg_index/cfg_data (index 0 bricks,
// index 1 ladders); cfg_ready is always high. The user must write only
// while idle; the block does not enforce it. A first or stopped request
// goes through evaluation and posting; a level or downward one also passes
// the finish step, and a climb refunded straight back with a ladder adds a
// refund step. A climb paid with bricks inserts into the heap with a check
// and a compare step per level walked up; a climb whose ladder moves onto a
// larger stored climb replaces the heap top with a check, a left read and a
// compare step per level walked down, both paced by the single memory read
// port. One request at a time: in_ready is high again in the cycle the
// result appears. The finished result sits in an output register, and a
// new request is taken while it waits for out_ready.
// Synchronous reset clears budgets, balance, position and flags; the heap
// memory is not cleared and is only read below its fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module budgeted_climb_reach_heap #(
  parameter int HEAP_DEPTH  = bcrh_pkg::HEAP_DEPTH_DEF,
  parameter int HEIGHT_BITS = bcrh_pkg::HEIGHT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire bcrh_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output bcrh_pkg::out_t                       out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bcrh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcrh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bcrh_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are always accepted
  assign cfg_ready = 1'b1;

  bcrh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bcrh_dp #(
    .HEAP_DEPTH  (HEAP_DEPTH),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
